// ===== hdl/ngs_pkg.sv =====
// ----------------------------------------------------------------------------
// ngs_pkg
// Shared types and constants for the Gentleman-Sande layer block: store
// geometry, request codes, Montgomery constants and sequencer types.
// ----------------------------------------------------------------------------
`default_nettype none

package ngs_pkg;

  // store geometry
  localparam int NUM_COEFFS = 256;
  localparam int COEF_AW    = $clog2(NUM_COEFFS);
  localparam int ROOT_DEPTH = NUM_COEFFS / 2;
  localparam int ROOT_AW    = $clog2(ROOT_DEPTH);
  localparam int LOG_W      = 3;
  localparam int DATA_W     = 32;

  // montgomery constants, R = 2^16
  localparam logic [DATA_W-1:0] MOD_Q    = 32'd3329;
  localparam logic [DATA_W-1:0] MOD_QINV = 32'd3327;
  localparam int                RED_W    = 16;

  // request codes
  localparam logic [1:0] ACT_WR_COEF = 2'd0;
  localparam logic [1:0] ACT_WR_ROOT = 2'd1;
  localparam logic [1:0] ACT_RUN     = 2'd2;
  localparam logic [1:0] ACT_RD_COEF = 2'd3;

  // result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // layer sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PROD,
    ST_QINV,
    ST_FOLD,
    ST_DONE
  } state_t;

  // steps of the shared multiplier
  typedef enum logic [1:0] {
    MS_PROD,
    MS_QINV,
    MS_FOLD
  } mstep_t;

  // sequencer to butterfly unit
  typedef struct packed {
    logic   en;
    mstep_t step;
  } bfly_ctl_t;

  // sequencer to store and output logic
  typedef struct packed {
    logic               busy;
    logic               wr_hi;
    logic               wr_lo;
    logic               done;
    logic [COEF_AW-1:0] addr_hi;
    logic [COEF_AW-1:0] addr_lo;
    logic [ROOT_AW-1:0] root_addr;
  } seq_t;

endpackage

`default_nettype wire

// ===== hdl/ngs_bfly.sv =====
// ----------------------------------------------------------------------------
// ngs_bfly
// Butterfly datapath around one shared 32x32 multiplier. The multiplier is
// used three times per butterfly: difference times root, low half times
// q', and the reduction factor times q.
// ----------------------------------------------------------------------------
`default_nettype none

module ngs_bfly (
  input  wire logic                             clk,
  input  wire ngs_pkg::bfly_ctl_t               ctl,
  input  wire logic [ngs_pkg::DATA_W-1:0]       u,
  input  wire logic [ngs_pkg::DATA_W-1:0]       v,
  input  wire logic [ngs_pkg::DATA_W-1:0]       w,
  output logic      [ngs_pkg::DATA_W-1:0]       sum,
  output logic      [ngs_pkg::DATA_W-1:0]       red
);

  logic [ngs_pkg::DATA_W-1:0]   op_a;
  logic [ngs_pkg::DATA_W-1:0]   op_b;
  logic [2*ngs_pkg::DATA_W-1:0] full;
  logic [ngs_pkg::DATA_W-1:0]   mul;
  logic [ngs_pkg::DATA_W-1:0]   fold;
  logic [ngs_pkg::DATA_W-1:0]   prod_r;
  logic [ngs_pkg::RED_W-1:0]    m_r;

  // operand select for the shared multiplier
  always_comb begin
    case (ctl.step)
      ngs_pkg::MS_PROD: begin
        op_a = u - v;
        op_b = w;
      end
      ngs_pkg::MS_QINV: begin
        op_a = {{(ngs_pkg::DATA_W-ngs_pkg::RED_W){1'b0}}, prod_r[ngs_pkg::RED_W-1:0]};
        op_b = ngs_pkg::MOD_QINV;
      end
      ngs_pkg::MS_FOLD: begin
        op_a = {{(ngs_pkg::DATA_W-ngs_pkg::RED_W){1'b0}}, m_r};
        op_b = ngs_pkg::MOD_Q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // shared multiplier, wraps at 32 bits
  assign full = op_a * op_b;
  assign mul  = full[ngs_pkg::DATA_W-1:0];

  // step registers
  always_ff @(posedge clk) begin
    if (ctl.en && ctl.step == ngs_pkg::MS_PROD) begin
      prod_r <= mul;
    end
    if (ctl.en && ctl.step == ngs_pkg::MS_QINV) begin
      m_r <= mul[ngs_pkg::RED_W-1:0];
    end
  end

  // upper entry and reduced lower entry, arithmetic shift by 16
  assign sum  = u + v;
  assign fold = prod_r + mul;
  assign red  = {{ngs_pkg::RED_W{fold[ngs_pkg::DATA_W-1]}},
                 fold[ngs_pkg::DATA_W-1:ngs_pkg::RED_W]};

endmodule

`default_nettype wire

// ===== hdl/ngs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ngs_ctrl
// Layer sequencer: walks the butterfly counter, forms pair and root
// addresses and steps the shared multiplier through each butterfly.
// ----------------------------------------------------------------------------
`default_nettype none

module ngs_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [1:0]                      action,
  input  wire logic [ngs_pkg::LOG_W-1:0]       log_half,
  output ngs_pkg::seq_t                        seq,
  output ngs_pkg::bfly_ctl_t                   bctl
);

  ngs_pkg::state_t                state_r;
  ngs_pkg::state_t                state_nxt;
  logic [ngs_pkg::ROOT_AW-1:0]    cnt_r;
  logic [ngs_pkg::ROOT_AW-1:0]    cnt_nxt;
  logic [ngs_pkg::LOG_W-1:0]      lh_r;
  logic [ngs_pkg::LOG_W-1:0]      lh_nxt;
  logic [ngs_pkg::ROOT_AW-1:0]    mask;
  logic [ngs_pkg::COEF_AW-1:0]    hi;
  logic                           run_req;
  logic                           last;

  assign run_req = start && (state_r == ngs_pkg::ST_IDLE) && (action == ngs_pkg::ACT_RUN);
  assign last    = (cnt_r == {ngs_pkg::ROOT_AW{1'b1}});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ngs_pkg::ST_IDLE: if (run_req) state_nxt = ngs_pkg::ST_READ;
      ngs_pkg::ST_READ: state_nxt = ngs_pkg::ST_PROD;
      ngs_pkg::ST_PROD: state_nxt = ngs_pkg::ST_QINV;
      ngs_pkg::ST_QINV: state_nxt = ngs_pkg::ST_FOLD;
      ngs_pkg::ST_FOLD: state_nxt = last ? ngs_pkg::ST_DONE : ngs_pkg::ST_READ;
      ngs_pkg::ST_DONE: state_nxt = ngs_pkg::ST_IDLE;
      default:          state_nxt = ngs_pkg::ST_IDLE;
    endcase
  end

  // counter and layer size
  always_comb begin
    cnt_nxt = cnt_r;
    lh_nxt  = lh_r;
    if (run_req) begin
      cnt_nxt = '0;
      lh_nxt  = log_half;
    end else if (state_r == ngs_pkg::ST_FOLD) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ngs_pkg::ST_IDLE;
      cnt_r   <= '0;
      lh_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lh_r    <= lh_nxt;
    end
  end

  // pair addresses: insert a zero bit at position log_half
  assign mask = ngs_pkg::ROOT_AW'((ngs_pkg::ROOT_AW+1)'(1) << lh_r) - 1'b1;
  assign hi   = {cnt_r & ~mask, 1'b0} | {1'b0, cnt_r & mask};

  // outputs
  always_comb begin
    seq.busy      = (state_r != ngs_pkg::ST_IDLE);
    seq.wr_hi     = 1'b0;
    seq.wr_lo     = 1'b0;
    seq.done      = 1'b0;
    seq.addr_hi   = hi;
    seq.addr_lo   = hi | (ngs_pkg::COEF_AW'(1) << lh_r);
    seq.root_addr = cnt_r;
    bctl.en       = 1'b0;
    bctl.step     = ngs_pkg::MS_PROD;
    case (state_r)
      ngs_pkg::ST_PROD: begin
        bctl.en     = 1'b1;
        bctl.step   = ngs_pkg::MS_PROD;
        seq.wr_hi   = 1'b1;
      end
      ngs_pkg::ST_QINV: begin
        bctl.en     = 1'b1;
        bctl.step   = ngs_pkg::MS_QINV;
      end
      ngs_pkg::ST_FOLD: begin
        bctl.en     = 1'b1;
        bctl.step   = ngs_pkg::MS_FOLD;
        seq.wr_lo   = 1'b1;
      end
      ngs_pkg::ST_DONE: seq.done = 1'b1;
      default: ;
    endcase
  end

  // checks
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(seq.wr_hi && seq.wr_lo))
    else $error("both pair entries written in one cycle");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_req |=> seq.busy)
    else $error("run request did not start the sequencer");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    seq.done |=> !seq.busy)
    else $error("sequencer stayed busy after layer done");

  a_pair_split: assert property (@(posedge clk) disable iff (!rst_n)
    seq.busy |-> (seq.addr_hi != seq.addr_lo))
    else $error("butterfly pair addresses collide");

endmodule

`default_nettype wire

// ===== hdl/ntt_gs_layer_montgomery_3329.sv =====
// ----------------------------------------------------------------------------
// ntt_gs_layer_montgomery_3329
// One Gentleman-Sande NTT layer over a 256-entry coefficient store with
// Montgomery reduction, q = 3329, R = 2^16.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on the rising edge where start is high and busy low.
//   in_action selects: write coefficient, write root, run one layer, read
//   coefficient. Writes give no result and leave busy low, so writes may
//   follow every cycle. A read returns out_kind = 0 and the coefficient on
//   out_data in the cycle after the request; reads may also go every cycle.
//   A run holds busy high while each of 128 butterflies steps through read,
//   product, q' and fold states, set by the single shared multiplier
//   (difference times root, times q', times q), then a done state with
//   out_strobe, out_kind = 1 and out_data = 0; busy drops the cycle after.
//   Results stand one cycle with out_strobe high; the receiver cannot stall.
//   Reset clears the sequencer and the pending read flag; both stores hold
//   unknown data until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_gs_layer_montgomery_3329 (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          in_action,
  input  wire logic [ngs_pkg::COEF_AW-1:0]         in_index,
  input  wire logic signed [ngs_pkg::DATA_W-1:0]   in_value,
  input  wire logic [ngs_pkg::LOG_W-1:0]           in_log_half,
  output logic                                     out_strobe,
  output logic                                     out_kind,
  output logic signed [ngs_pkg::DATA_W-1:0]        out_data
);

  ngs_pkg::seq_t                 seq;
  ngs_pkg::bfly_ctl_t            bctl;
  logic [ngs_pkg::DATA_W-1:0]    coef_mem [ngs_pkg::NUM_COEFFS];
  logic [ngs_pkg::DATA_W-1:0]    root_mem [ngs_pkg::ROOT_DEPTH];
  logic [ngs_pkg::DATA_W-1:0]    rda_r;
  logic [ngs_pkg::DATA_W-1:0]    rdb_r;
  logic [ngs_pkg::DATA_W-1:0]    root_r;
  logic [ngs_pkg::DATA_W-1:0]    sum;
  logic [ngs_pkg::DATA_W-1:0]    red;
  logic [ngs_pkg::COEF_AW-1:0]   rda_addr;
  logic                          req;
  logic                          rd_pend_r;
  logic                          rd_pend_nxt;

  assign busy = seq.busy;
  assign req  = start && !seq.busy;

  ngs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .action   (in_action),
    .log_half (in_log_half),
    .seq      (seq),
    .bctl     (bctl)
  );

  ngs_bfly u_bfly (
    .clk (clk),
    .ctl (bctl),
    .u   (rda_r),
    .v   (rdb_r),
    .w   (root_r),
    .sum (sum),
    .red (red)
  );

  // coefficient store: one write port, two registered read ports
  assign rda_addr = seq.busy ? seq.addr_hi : in_index;

  always_ff @(posedge clk) begin
    if (req && in_action == ngs_pkg::ACT_WR_COEF) begin
      coef_mem[in_index] <= in_value;
    end else if (seq.wr_hi) begin
      coef_mem[seq.addr_hi] <= sum;
    end else if (seq.wr_lo) begin
      coef_mem[seq.addr_lo] <= red;
    end
    rda_r <= coef_mem[rda_addr];
    rdb_r <= coef_mem[seq.addr_lo];
  end

  // root store, writes at or above the depth are dropped
  always_ff @(posedge clk) begin
    if (req && in_action == ngs_pkg::ACT_WR_ROOT && !in_index[ngs_pkg::COEF_AW-1]) begin
      root_mem[in_index[ngs_pkg::ROOT_AW-1:0]] <= in_value;
    end
    root_r <= root_mem[seq.root_addr];
  end

  // pending read result
  assign rd_pend_nxt = req && (in_action == ngs_pkg::ACT_RD_COEF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // result port
  assign out_strobe = rd_pend_r || seq.done;
  assign out_kind   = seq.done ? ngs_pkg::KIND_DONE : ngs_pkg::KIND_READ;
  assign out_data   = seq.done ? '0 : signed'(rda_r);

endmodule

`default_nettype wire

// ===== dv/ntt_gs_layer_montgomery_3329_tb.sv =====
// ----------------------------------------------------------------------------
// ntt_gs_layer_montgomery_3329_tb
// Self-checking bench for the Gentleman-Sande layer block. Both stores are
// filled first so that no read or layer ever touches an unwritten entry.
// A short table of requests follows: extremes, dropped root writes and
// every layer size. Then a long mix of random loads, reads, single layers
// and full eight-layer sweeps. A scoreboard model of both stores predicts
// each untyped reply, and the replies are checked in order as they come out.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_gs_layer_montgomery_3329_tb;

  localparam int RAND_ITEMS     = 1150;
  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int IDLE_PCT       = 21;
  localparam int DIR_ROWS       = 23;

  typedef struct packed {
    logic                       kind;
    logic [ngs_pkg::DATA_W-1:0] data;
  } reply_t;

  typedef struct packed {
    logic [1:0]                  action;
    logic [ngs_pkg::COEF_AW-1:0] index;
    logic [ngs_pkg::DATA_W-1:0]  value;
    logic [ngs_pkg::LOG_W-1:0]   log_half;
    logic                        typed;
    reply_t                      reply;
  } dir_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [1:0]                        in_action;
  logic [ngs_pkg::COEF_AW-1:0]       in_index;
  logic signed [ngs_pkg::DATA_W-1:0] in_value;
  logic [ngs_pkg::LOG_W-1:0]         in_log_half;
  logic                              out_strobe;
  logic                              out_kind;
  logic signed [ngs_pkg::DATA_W-1:0] out_data;

  // scoreboard copy of both stores
  logic [ngs_pkg::DATA_W-1:0] coef_model [ngs_pkg::NUM_COEFFS];
  logic [ngs_pkg::DATA_W-1:0] root_model [ngs_pkg::ROOT_DEPTH];
  reply_t                     pending_replies [$];
  reply_t                     head_reply;
  int                         fail_cnt = 0;
  int                         idle_cnt = 0;
  bit                         quiet = 1'b0;

  // directed requests; typed replies only where obvious
  dir_row_t dir_table [DIR_ROWS] = '{
    '{ngs_pkg::ACT_WR_COEF, 8'd0,   32'h7FFF_FFFF, 3'd0, 1'b0, '{ngs_pkg::KIND_READ, 32'd0}},
    '{ngs_pkg::ACT_RD_COEF, 8'd0,   32'd0,         3'd0, 1'b1,
      '{ngs_pkg::KIND_READ, 32'h7FFF_FFFF}},
    '{ngs_pkg::ACT_WR_COEF, 8'd255, 32'h8000_0000, 3'd7, 1'b0, '{ngs_pkg::KIND_READ, 32'd0}},
    '{ngs_pkg::ACT_RD_COEF, 8'd255, 32'hFFFF_FFFF, 3'd7, 1'b1,
      '{ngs_pkg::KIND_READ, 32'h8000_0000}},
    '{ngs_pkg::ACT_WR_COEF, 8'd128, 32'hFFFF_FFFF, 3'd5, 1'b0, '{ngs_pkg::KIND_READ, 32'd0}},
    '{ngs_pkg::ACT_RD_COEF, 8'd128, 32'd0,         3'd2, 1'b1,
      '{ngs_pkg::KIND_READ, 32'hFFFF_FFFF}},
    '{ngs_pkg::ACT_WR_COEF, 8'd1,   32'd0,         3'd0, 1'b0, '{ngs_pkg::KIND_READ, 32'd0}},
    '{ngs_pkg::ACT_RD_COEF, 8'd1,   32'h5555_5555, 3'd0, 1'b1, '{ngs_pkg::KIND_READ, 32'd0}},
    '{ngs_pkg::ACT_WR_ROOT, 8'd0,   32'h7FFF_FFFF, 3'd0, 1'b0, '{ngs_pkg::KIND_READ, 32'd0}},
    '{ngs_pkg::ACT_WR_ROOT, 8'd127, 32'h8000_0000, 3'd0, 1'b0, '{ngs_pkg::KIND_READ, 32'd0}},
    // root writes past the root store are dropped
    '{ngs_pkg::ACT_WR_ROOT, 8'd128, 32'h5A5A_5A5A, 3'd0, 1'b0, '{ngs_pkg::KIND_READ, 32'd0}},
    '{ngs_pkg::ACT_WR_ROOT, 8'd255, 32'hFFFF_FFFF, 3'd7, 1'b0, '{ngs_pkg::KIND_READ, 32'd0}},
    '{ngs_pkg::ACT_RUN,     8'd0,   32'd0,         3'd0, 1'b1, '{ngs_pkg::KIND_DONE, 32'd0}},
    '{ngs_pkg::ACT_RUN,     8'd255, 32'hFFFF_FFFF, 3'd1, 1'b1, '{ngs_pkg::KIND_DONE, 32'd0}},
    '{ngs_pkg::ACT_RUN,     8'd0,   32'd0,         3'd2, 1'b1, '{ngs_pkg::KIND_DONE, 32'd0}},
    '{ngs_pkg::ACT_RUN,     8'd0,   32'd0,         3'd3, 1'b1, '{ngs_pkg::KIND_DONE, 32'd0}},
    '{ngs_pkg::ACT_RUN,     8'd0,   32'd0,         3'd4, 1'b1, '{ngs_pkg::KIND_DONE, 32'd0}},
    '{ngs_pkg::ACT_RUN,     8'd0,   32'd0,         3'd5, 1'b1, '{ngs_pkg::KIND_DONE, 32'd0}},
    '{ngs_pkg::ACT_RUN,     8'd0,   32'd0,         3'd6, 1'b1, '{ngs_pkg::KIND_DONE, 32'd0}},
    '{ngs_pkg::ACT_RUN,     8'd0,   32'd0,         3'd7, 1'b1, '{ngs_pkg::KIND_DONE, 32'd0}},
    '{ngs_pkg::ACT_RD_COEF, 8'd0,   32'd0,         3'd0, 1'b0, '{ngs_pkg::KIND_READ, 32'd0}},
    '{ngs_pkg::ACT_RD_COEF, 8'd128, 32'd0,         3'd0, 1'b0, '{ngs_pkg::KIND_READ, 32'd0}},
    '{ngs_pkg::ACT_RD_COEF, 8'd255, 32'd0,         3'd0, 1'b0, '{ngs_pkg::KIND_READ, 32'd0}}
  };

  ntt_gs_layer_montgomery_3329 u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_action   (in_action),
    .in_index    (in_index),
    .in_value    (in_value),
    .in_log_half (in_log_half),
    .out_strobe  (out_strobe),
    .out_kind    (out_kind),
    .out_data    (out_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // montgomery product, R = 2^16, no final subtraction
  function automatic logic [ngs_pkg::DATA_W-1:0] mont_product(
      logic [ngs_pkg::DATA_W-1:0] a, logic [ngs_pkg::DATA_W-1:0] b);
    logic [ngs_pkg::DATA_W-1:0] prod;
    logic [ngs_pkg::DATA_W-1:0] m;
    logic [ngs_pkg::DATA_W-1:0] t;
    prod = a * b;
    m    = ((prod & 32'h0000_FFFF) * ngs_pkg::MOD_QINV) & 32'h0000_FFFF;
    t    = prod + m * ngs_pkg::MOD_Q;
    return $signed(t) >>> ngs_pkg::RED_W;
  endfunction

  // one gentleman-sande layer over the model store
  task automatic run_gs_layer(input logic [ngs_pkg::LOG_W-1:0] log_half);
    int                         half;
    int                         span;
    int                         hi;
    int                         lo;
    int                         ri;
    logic [ngs_pkg::DATA_W-1:0] u;
    logic [ngs_pkg::DATA_W-1:0] v;
    logic [ngs_pkg::DATA_W-1:0] w;
    half = 1 << log_half;
    span = 2 * half;
    for (int base = 0; base + span <= ngs_pkg::NUM_COEFFS; base += span) begin
      for (int i = 0; i < half; i++) begin
        hi = base + i;
        lo = hi + half;
        ri = i + (base / span) * half;
        u  = coef_model[hi];
        v  = coef_model[lo];
        w  = (ri < ngs_pkg::ROOT_DEPTH) ? root_model[ri] : '0;
        coef_model[hi] = u + v;
        coef_model[lo] = mont_product(u - v, w);
      end
    end
  endtask

  // update the model with one request and work out its reply
  task automatic apply_request(input logic [1:0] action,
                               input logic [ngs_pkg::COEF_AW-1:0] index,
                               input logic [ngs_pkg::DATA_W-1:0] value,
                               input logic [ngs_pkg::LOG_W-1:0] log_half,
                               output bit has_reply, output reply_t reply);
    has_reply = 1'b0;
    reply     = '0;
    case (action)
      ngs_pkg::ACT_WR_COEF: begin
        coef_model[index] = value;
      end
      ngs_pkg::ACT_WR_ROOT: begin
        if (index < ngs_pkg::ROOT_DEPTH) root_model[index] = value;
      end
      ngs_pkg::ACT_RUN: begin
        run_gs_layer(log_half);
        has_reply = 1'b1;
        reply     = '{ngs_pkg::KIND_DONE, '0};
      end
      default: begin
        has_reply = 1'b1;
        reply     = '{ngs_pkg::KIND_READ, coef_model[index]};
      end
    endcase
  endtask

  // mix of full random words, small residues and extremes
  function automatic logic [ngs_pkg::DATA_W-1:0] rand_word();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return $urandom_range(0, 6658) - 3329;
      7:          return 32'h7FFF_FFFF;
      8:          return 32'h8000_0000;
      default:    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    endcase
  endfunction

  // present one request, with random idle cycles ahead of it
  task automatic send_request(input logic [1:0] action,
                              input logic [ngs_pkg::COEF_AW-1:0] index,
                              input logic [ngs_pkg::DATA_W-1:0] value,
                              input logic [ngs_pkg::LOG_W-1:0] log_half,
                              input bit typed = 1'b0, input reply_t typed_reply = '0);
    bit     has_reply;
    reply_t reply;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      start       <= 1'b0;
      in_action   <= 2'($urandom_range(0, 3));
      in_index    <= ngs_pkg::COEF_AW'($urandom());
      in_value    <= $urandom();
      in_log_half <= ngs_pkg::LOG_W'($urandom());
      @(negedge clk);
    end
    start       <= 1'b1;
    in_action   <= action;
    in_index    <= index;
    in_value    <= value;
    in_log_half <= log_half;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    apply_request(action, index, value, log_half, has_reply, reply);
    if (has_reply) pending_replies.push_back(typed ? typed_reply : reply);
  endtask

  // reply checker
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_replies.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("unexpected reply: kind %b data %h", out_kind, out_data);
      end else begin
        head_reply = pending_replies.pop_front();
        if (out_kind !== head_reply.kind || out_data !== head_reply.data) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("reply mismatch: kind exp %b got %b, data exp %h got %h",
                     head_reply.kind, out_kind, head_reply.data, out_data);
        end
      end
    end
  end

  // watchdog on cycles with no request and no reply taken
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // stimulus
  initial begin
    int pick;
    int sel;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = ngs_pkg::ACT_WR_COEF;
    in_index    = '0;
    in_value    = '0;
    in_log_half = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // fill both stores so nothing unwritten is ever used
    for (int i = 0; i < ngs_pkg::NUM_COEFFS; i++)
      send_request(ngs_pkg::ACT_WR_COEF, ngs_pkg::COEF_AW'(i), rand_word(),
                   ngs_pkg::LOG_W'($urandom()));
    for (int i = 0; i < ngs_pkg::ROOT_DEPTH; i++)
      send_request(ngs_pkg::ACT_WR_ROOT, ngs_pkg::COEF_AW'(i), rand_word(),
                   ngs_pkg::LOG_W'($urandom()));

    // directed table
    foreach (dir_table[r])
      send_request(dir_table[r].action, dir_table[r].index, dir_table[r].value,
                   dir_table[r].log_half, dir_table[r].typed, dir_table[r].reply);

    // random mix, with a long stretch free of idle cycles
    for (int item = 0; item < RAND_ITEMS; item++) begin
      quiet = (item >= 400 && item < 700);
      pick  = $urandom_range(0, 99);
      if (pick < 38) begin
        send_request(ngs_pkg::ACT_WR_COEF, ngs_pkg::COEF_AW'($urandom()), rand_word(),
                     ngs_pkg::LOG_W'($urandom()));
      end else if (pick < 54) begin
        sel = $urandom_range(0, 99);
        send_request(ngs_pkg::ACT_WR_ROOT,
                     (sel < 75) ? ngs_pkg::COEF_AW'($urandom_range(0, 127))
                                : ngs_pkg::COEF_AW'($urandom_range(128, 255)),
                     rand_word(), ngs_pkg::LOG_W'($urandom()));
      end else if (pick < 94) begin
        send_request(ngs_pkg::ACT_RD_COEF, ngs_pkg::COEF_AW'($urandom()), $urandom(),
                     ngs_pkg::LOG_W'($urandom()));
      end else if (pick < 98) begin
        send_request(ngs_pkg::ACT_RUN, ngs_pkg::COEF_AW'($urandom()), $urandom(),
                     ngs_pkg::LOG_W'($urandom()));
      end else begin
        // full inverse transform: every layer, smallest first
        for (int lh = 0; lh < 8; lh++)
          send_request(ngs_pkg::ACT_RUN, ngs_pkg::COEF_AW'($urandom()), $urandom(),
                       ngs_pkg::LOG_W'(lh));
      end
    end
    quiet = 1'b0;
    @(negedge clk);
    start <= 1'b0;

    // drain outstanding replies
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/ngs_pkg.sv
hdl/ngs_bfly.sv
hdl/ngs_ctrl.sv
hdl/ntt_gs_layer_montgomery_3329.sv
dv/ntt_gs_layer_montgomery_3329_tb.sv
